>>> sv/prp_pkg.sv
// shared types and constants for the page replacement policy block
package prp_pkg;
	localparam logic [1:0] MODE_FIFO = 2'd0;
	localparam logic [1:0] MODE_RAND = 2'd1;
	localparam logic [1:0] MODE_LFC  = 2'd2;

	localparam logic [1:0] REG_MODE   = 2'd0;
	localparam logic [1:0] REG_FRAMES = 2'd1;
	localparam logic [1:0] REG_SEED   = 2'd2;

	localparam logic [31:0] LFSR_TAPS = 32'hA300_0000;

	// classified job handed from front to back
	typedef struct packed {
		logic [1:0]  mode;
		logic [7:0]  page;
		logic [6:0]  frames;
	} prp_job_t;

	function automatic logic [31:0] lfsr_next(input logic [31:0] v);
		logic [31:0] n;
		n = {1'b0, v[31:1]};
		if (v[0]) begin
			n = n ^ LFSR_TAPS;
		end
		return n;
	endfunction
endpackage

>>> sv/prp_front.sv
// front end: accepts faults, drops invalid ones, queues the rest
module prp_front import prp_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic [7:0]     fault_page,
	input  logic [1:0]     mode,
	input  logic [6:0]     frames,
	output logic           job_valid,
	input  logic           job_take,
	output prp_job_t       job
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	prp_job_t       mem_q [DEPTH];
	logic [AW-1:0]  wr_q, rd_q;
	logic [AW:0]    cnt_q;
	logic           push;

	assign in_stall = (cnt_q == (AW+1)'(DEPTH));
	// mode 3 faults are swallowed without a result
	assign push = in_valid && !in_stall && (mode != 2'd3);
	assign job_valid = (cnt_q != '0);
	assign job = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= '{mode: mode, page: fault_page, frames: frames};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
			end
			if (job_take) begin
				rd_q <= (rd_q == AW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(job_take);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) !(job_take && !job_valid))
		else $error("pop of empty queue");
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= (AW+1)'(DEPTH))
		else $error("queue overfilled");
	assert property (@(posedge clk) disable iff (!arst_n) !(push && mode == 2'd3))
		else $error("unused mode queued");
endmodule

>>> sv/prp_back.sv
// back end: victim selection, store updates and result register
module prp_back import prp_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_valid,
	output logic           job_take,
	input  prp_job_t       job,
	input  logic           seed_load,
	input  logic [31:0]    seed,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [5:0]     victim_frame,
	output logic [7:0]     evicted_page,
	output logic           read_from_disk,
	output logic [31:0]    fault_total,
	output logic [31:0]    write_total,
	output logic [31:0]    read_total
);
	localparam logic [3:0] ST_INIT = 4'd0, ST_IDLE = 4'd1, ST_CINC = 4'd2,
		ST_CWR = 4'd3, ST_SCAN = 4'd4, ST_SCNT = 4'd5, ST_CMP = 4'd6,
		ST_OWN = 4'd7, ST_UPD = 4'd8, ST_DSK = 4'd9, ST_OUT = 4'd10,
		ST_MOD = 4'd11;

	logic [3:0]  st_q;
	logic [7:0]  own_mem [64];
	logic [15:0] cnt_mem [256];
	logic        dsk_mem [256];
	logic [7:0]  own_rd_q, cnt_addr, dsk_addr;
	logic [15:0] cnt_rd_q;
	logic        dsk_rd_q, own_we, cnt_we, dsk_we, dsk_wd;
	logic [5:0]  own_addr;
	logic [7:0]  own_wd;
	logic [15:0] cnt_wd;
	logic [8:0]  init_q;
	logic [5:0]  ptr_q, idx_q, frame_q, best_f_q;
	logic [15:0] best_q;
	logic [31:0] lfsr_q, fc_q, wc_q, rc_q;
	logic [6:0]  n;
	logic [7:0]  evict_q;
	logic        dphase_q;
	logic        rd_q;
	logic [31:0] dsh_q;
	logic [6:0]  rem_q, mod_t, mod_r;
	logic [4:0]  bit_q;
	prp_job_t    job_q;

	always_comb begin
		n = job_q.frames;
		if (n == 7'd0) n = 7'd1;
		if (n > 7'd64) n = 7'd64;
	end

	// one remainder bit per cycle, partial remainder stays below n
	always_comb begin
		mod_t = {rem_q[5:0], dsh_q[31]};
		mod_r = (mod_t >= n) ? mod_t - n : mod_t;
	end

	// memories
	always_ff @(posedge clk) begin
		if (own_we) own_mem[own_addr] <= own_wd;
		own_rd_q <= own_mem[own_addr];
		if (cnt_we) cnt_mem[cnt_addr] <= cnt_wd;
		cnt_rd_q <= cnt_mem[cnt_addr];
		if (dsk_we) dsk_mem[dsk_addr] <= dsk_wd;
		dsk_rd_q <= dsk_mem[dsk_addr];
	end

	always_comb begin
		own_we = 1'b0; own_addr = idx_q; own_wd = job_q.page;
		cnt_we = 1'b0; cnt_addr = job_q.page; cnt_wd = cnt_rd_q;
		dsk_we = 1'b0; dsk_addr = job_q.page; dsk_wd = 1'b0;
		case (st_q)
			ST_INIT: begin
				own_we = !init_q[8] && (init_q[7:6] == 2'd0);
				own_addr = init_q[5:0]; own_wd = init_q[7:0];
				cnt_we = !init_q[8]; cnt_addr = init_q[7:0]; cnt_wd = '0;
				dsk_we = !init_q[8]; dsk_addr = init_q[7:0]; dsk_wd = 1'b0;
			end
			ST_CWR: begin
				cnt_we = 1'b1;
				cnt_wd = (cnt_rd_q == 16'hFFFF) ? cnt_rd_q : cnt_rd_q + 16'd1;
			end
			ST_SCNT: cnt_addr = own_rd_q;
			ST_OWN: own_addr = frame_q;
			ST_UPD: begin
				own_we = 1'b1; own_addr = frame_q;
				dsk_we = 1'b1; dsk_addr = own_rd_q; dsk_wd = 1'b1;
			end
			ST_DSK: begin
				// read then clear the faulting page mark
				dsk_we = dphase_q;
			end
			default: ;
		endcase
	end

	assign job_take = (st_q == ST_IDLE) && job_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_INIT; init_q <= '0; ptr_q <= '0; lfsr_q <= 32'd1;
			fc_q <= '0; wc_q <= '0; rc_q <= '0; out_valid <= 1'b0;
			idx_q <= '0; frame_q <= '0; best_f_q <= '0; best_q <= '0;
			evict_q <= '0; dphase_q <= 1'b0; job_q <= '0; rd_q <= 1'b0;
			dsh_q <= '0; rem_q <= '0; bit_q <= '0;
			victim_frame <= '0; evicted_page <= '0; read_from_disk <= 1'b0;
			fault_total <= '0; write_total <= '0; read_total <= '0;
		end else begin
			if (seed_load) lfsr_q <= seed;
			if (out_valid && !out_stall && st_q != ST_OUT) out_valid <= 1'b0;
			case (st_q)
				ST_INIT: begin
					init_q <= init_q + 9'd1;
					if (init_q[8]) st_q <= ST_IDLE;
				end
				ST_IDLE: if (job_take) begin
					job_q <= job;
					st_q <= ST_CINC;
				end
				ST_CINC: begin
					fc_q <= fc_q + 32'd1;
					if (job_q.mode == MODE_FIFO) begin
						frame_q <= (7'(ptr_q) < n) ? ptr_q : 6'd0;
						ptr_q <= ((7'(ptr_q) < n ? 7'(ptr_q) : 7'd0) + 7'd1 >= n) ? 6'd0
							: 6'((7'(ptr_q) < n ? 7'(ptr_q) : 7'd0) + 7'd1);
						st_q <= ST_OWN;
					end else if (job_q.mode == MODE_RAND) begin
						lfsr_q <= lfsr_next(lfsr_q);
						// remainder of the new lfsr value, msb first
						dsh_q <= lfsr_next(lfsr_q);
						rem_q <= '0;
						bit_q <= '0;
						st_q <= ST_MOD;
					end else begin
						st_q <= ST_CWR;
					end
				end
				ST_MOD: begin
					rem_q <= mod_r;
					dsh_q <= {dsh_q[30:0], 1'b0};
					bit_q <= bit_q + 5'd1;
					if (bit_q == 5'd31) begin
						frame_q <= mod_r[5:0];
						st_q <= ST_OWN;
					end
				end
				ST_CWR: begin
					idx_q <= '0; best_f_q <= '0; best_q <= 16'hFFFF;
					st_q <= ST_SCAN;
				end
				ST_SCAN: st_q <= ST_SCNT;
				ST_SCNT: st_q <= ST_CMP;
				ST_CMP: begin
					if (idx_q == 6'd0 || cnt_rd_q < best_q) begin
						best_q <= cnt_rd_q; best_f_q <= idx_q;
					end
					if (7'(idx_q) + 7'd1 >= n) begin
						frame_q <= (idx_q == 6'd0 || cnt_rd_q < best_q) ? idx_q : best_f_q;
						st_q <= ST_OWN;
					end else begin
						idx_q <= idx_q + 6'd1;
						st_q <= ST_SCAN;
					end
				end
				ST_OWN: st_q <= ST_UPD;
				ST_UPD: begin
					evict_q <= own_rd_q; wc_q <= wc_q + 32'd1;
					dphase_q <= 1'b0; st_q <= ST_DSK;
				end
				ST_DSK: begin
					if (!dphase_q) dphase_q <= 1'b1;
					else begin
						// hold the mark, the memory read moves on after the clear
						rd_q <= dsk_rd_q;
						st_q <= ST_OUT;
					end
				end
				ST_OUT: if (!out_valid || !out_stall) begin
					out_valid <= 1'b1;
					victim_frame <= frame_q; evicted_page <= evict_q;
					read_from_disk <= rd_q;
					rc_q <= rc_q + 32'(rd_q);
					fault_total <= fc_q; write_total <= wc_q;
					read_total <= rc_q + 32'(rd_q);
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) job_take |-> st_q == ST_IDLE)
		else $error("take outside idle");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(victim_frame))
		else $error("stalled result moved");
	assert property (@(posedge clk) disable iff (!arst_n) st_q == ST_CMP |-> 7'(idx_q) < n)
		else $error("scan overrun");
endmodule

>>> sv/page_replacement_policy.sv
// top level of the page replacement policy block
// the back end sequencer handles one fault at a time and takes the next only when idle;
// random mode runs a 32-step remainder of the new lfsr value to pick a frame, and
// least-count mode scans the frames in use through the count memory (scan, read, compare)
// reset: clears registers, then a clearing pass over the stores,
// faults are queued but not processed until it ends
module page_replacement_policy import prp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  fault_page,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [5:0]  victim_frame,
	output logic [7:0]  evicted_page,
	output logic        read_from_disk,
	output logic [31:0] fault_total,
	output logic [31:0] write_total,
	output logic [31:0] read_total,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	logic [1:0]  mode_q;
	logic [6:0]  frames_q;
	logic        job_valid, job_take, cfg_wr;
	prp_job_t    job;

	// config writes always accepted
	assign cfg_ready = 1'b1;
	assign cfg_wr = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_FIFO;
			frames_q <= 7'd64;
		end else if (cfg_wr) begin
			if (cfg_index == REG_MODE) mode_q <= cfg_data[1:0];
			if (cfg_index == REG_FRAMES) frames_q <= cfg_data[6:0];
		end
	end

	prp_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .fault_page,
		.mode(mode_q), .frames(frames_q),
		.job_valid, .job_take, .job
	);

	prp_back u_back (
		.clk, .arst_n, .job_valid, .job_take, .job,
		.seed_load(cfg_wr && cfg_index == REG_SEED), .seed(cfg_data),
		.out_valid, .out_stall, .victim_frame, .evicted_page, .read_from_disk,
		.fault_total, .write_total, .read_total
	);
endmodule
